// File: hw/rtl/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, constants and helpers of the vertex rotate and project block.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int VERTEX_COUNT_DEF = 8;
  localparam int COORD_W  = 32;
  localparam int CS_W     = 18;
  localparam int VD_W     = 24;
  localparam int PIX_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int A_W      = 34;
  localparam int ACC_W    = 53;
  localparam int DEN_W    = 34;
  localparam int DABS_W   = 33;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [2:0] KIND_LIMIT = 3'd6;

  localparam logic [1:0] PAIR_YZ = 2'd1;
  localparam logic [1:0] PAIR_XY = 2'd2;

  localparam logic [2:0] OP_U_COS = 3'd0;
  localparam logic [2:0] OP_U_SIN = 3'd1;
  localparam logic [2:0] OP_V_COS = 3'd2;
  localparam logic [2:0] OP_V_SIN = 3'd3;
  localparam logic [2:0] OP_X_SCL = 3'd4;
  localparam logic [2:0] OP_X_CTR = 3'd5;
  localparam logic [2:0] OP_Y_SCL = 3'd6;
  localparam logic [2:0] OP_Y_CTR = 3'd7;

  localparam logic [CS_W-1:0]  COS_RST   = 18'd65526;
  localparam logic [CS_W-1:0]  SIN_RST   = 18'd1144;
  localparam logic [VD_W-1:0]  VD_RST    = 24'd327680;
  localparam logic [PIX_W-1:0] SCALE_RST = 16'd200;
  localparam logic [PIX_W-1:0] CTR_X_RST = 16'd320;
  localparam logic [PIX_W-1:0] CTR_Y_RST = 16'd240;

  typedef enum logic [2:0] {
    REG_COS, REG_SIN, REG_VD, REG_SCALE, REG_CTR_X, REG_CTR_Y
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LATCH, ST_MUL, ST_RND_U, ST_RND_V,
    ST_WBACK, ST_DEN, ST_DIV, ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_req_t;

  // round q.32 to q.16, ties away from zero, saturate to 32 bit
  function automatic logic [COORD_W-1:0] round_sat(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0]        t;
    logic [ACC_W-FRAC_W-1:0] r;
    logic [ACC_W-FRAC_W-COORD_W:0] hi;
    t  = v + (v[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768));
    r  = t[ACC_W-1:FRAC_W];
    hi = r[ACC_W-FRAC_W-1:COORD_W-1];
    if ((&hi) || !(|hi)) begin
      return r[COORD_W-1:0];
    end else if (r[ACC_W-FRAC_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: hw/rtl/vertex_rotate_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Vertex store with rotation by a configured angle and perspective projection.
// ----------------------------------------------------------------------------
// A rotate keeps busy high while, per vertex, up to eight products run on
// the bit-serial multiplier (four when rotation_kind_i selects no rotation)
// and up to two passes run on the serial divider (none when the denominator
// is zero), plus control states. One result per vertex is strobed on
// out_valid_o for a single cycle, in index order; the receiver cannot stall,
// so it must take every beat as it comes.
module vertex_rotate_project #(
  parameter int VERTEX_COUNT = vrp_pkg::VERTEX_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               req_type_i,
  input  logic [2:0]                         vertex_index_i,
  input  logic [vrp_pkg::COORD_W-1:0]        load_x_i,
  input  logic [vrp_pkg::COORD_W-1:0]        load_y_i,
  input  logic [vrp_pkg::COORD_W-1:0]        load_z_i,
  input  logic [2:0]                         rotation_kind_i,
  output logic                               out_valid_o,
  output logic [2:0]                         out_index_o,
  output logic [vrp_pkg::COORD_W-1:0]        rot_x_o,
  output logic [vrp_pkg::COORD_W-1:0]        rot_y_o,
  output logic [vrp_pkg::COORD_W-1:0]        rot_z_o,
  output logic [vrp_pkg::PIX_W-1:0]          pixel_x_o,
  output logic [vrp_pkg::PIX_W-1:0]          pixel_y_o,
  output logic                               div_fault_o,
  output logic                               last_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vrp_pkg::ADDR_W-1:0]         paddr,
  input  logic [vrp_pkg::DATA_W-1:0]         pwdata,
  output logic [vrp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int IDX_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int CW    = vrp_pkg::COORD_W;

  vrp_pkg::state_e state_q, state_d;
  vrp_pkg::mac_req_t mac_q, mac_d;

  logic [vrp_pkg::CS_W-1:0]  cos_q, sin_q;
  logic [vrp_pkg::VD_W-1:0]  vd_q;
  logic [vrp_pkg::PIX_W-1:0] scale_q, ctr_x_q, ctr_y_q;

  logic [IDX_W-1:0]          idx_q;
  logic [2:0]                kind_q;
  logic [2:0]                op_q, op_d;
  logic                      div_go_q, div_go_d;
  logic [CW-1:0]             vx_q, vy_q, vz_q, nu_q, nv_q;
  logic [CW-1:0]             rd_x_q, rd_y_q, rd_z_q;
  logic [vrp_pkg::DEN_W-1:0] den_q;
  logic [vrp_pkg::PIX_W-1:0] px_q, py_q;
  logic                      fault_q;

  logic [CW-1:0] mem_x [VERTEX_COUNT];
  logic [CW-1:0] mem_y [VERTEX_COUNT];
  logic [CW-1:0] mem_z [VERTEX_COUNT];

  logic                       cfg_wr, load_go, rot_go, idx_last, rotating, den_zero, odd;
  logic [1:0]                 pair;
  logic [CW-1:0]              u_val, v_val, wx, wy, wz;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_addr;
  logic [CW-1:0]              mem_dx, mem_dy, mem_dz;
  logic [vrp_pkg::A_W-1:0]    mac_a;
  logic [vrp_pkg::CS_W-1:0]   mac_b;
  logic [vrp_pkg::ACC_W-1:0]  acc, mag, num;
  logic [vrp_pkg::DEN_W-1:0]  den_neg;
  logic [vrp_pkg::DABS_W-1:0] dabs;
  logic [vrp_pkg::PIX_W-1:0]  quot;
  logic                       mac_done, div_done;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= vrp_pkg::COS_RST;
      sin_q   <= vrp_pkg::SIN_RST;
      vd_q    <= vrp_pkg::VD_RST;
      scale_q <= vrp_pkg::SCALE_RST;
      ctr_x_q <= vrp_pkg::CTR_X_RST;
      ctr_y_q <= vrp_pkg::CTR_Y_RST;
    end else if (cfg_wr) begin
      case (vrp_pkg::reg_e'(paddr[4:2]))
        vrp_pkg::REG_COS:   cos_q   <= pwdata[vrp_pkg::CS_W-1:0];
        vrp_pkg::REG_SIN:   sin_q   <= pwdata[vrp_pkg::CS_W-1:0];
        vrp_pkg::REG_VD:    vd_q    <= pwdata[vrp_pkg::VD_W-1:0];
        vrp_pkg::REG_SCALE: scale_q <= pwdata[vrp_pkg::PIX_W-1:0];
        vrp_pkg::REG_CTR_X: ctr_x_q <= pwdata[vrp_pkg::PIX_W-1:0];
        vrp_pkg::REG_CTR_Y: ctr_y_q <= pwdata[vrp_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (vrp_pkg::reg_e'(paddr[4:2]))
      vrp_pkg::REG_COS:   prdata = {{(vrp_pkg::DATA_W-vrp_pkg::CS_W){cos_q[vrp_pkg::CS_W-1]}}, cos_q};
      vrp_pkg::REG_SIN:   prdata = {{(vrp_pkg::DATA_W-vrp_pkg::CS_W){sin_q[vrp_pkg::CS_W-1]}}, sin_q};
      vrp_pkg::REG_VD:    prdata = vrp_pkg::DATA_W'(vd_q);
      vrp_pkg::REG_SCALE: prdata = vrp_pkg::DATA_W'(scale_q);
      vrp_pkg::REG_CTR_X: prdata = vrp_pkg::DATA_W'(ctr_x_q);
      vrp_pkg::REG_CTR_Y: prdata = vrp_pkg::DATA_W'(ctr_y_q);
      default:            prdata = '0;
    endcase
  end

  // beat acceptance
  assign busy     = (state_q != vrp_pkg::ST_IDLE);
  assign load_go  = start && !busy && !req_type_i;
  assign rot_go   = start && !busy && req_type_i;
  assign idx_last = (idx_q == IDX_W'(VERTEX_COUNT - 1));
  assign rotating = (kind_q < vrp_pkg::KIND_LIMIT);
  assign pair     = kind_q[2:1];
  assign odd      = kind_q[0];
  assign den_zero = (den_q == '0);

  // rotation pair selection
  assign u_val = (pair == vrp_pkg::PAIR_YZ) ? vy_q : vx_q;
  assign v_val = (pair == vrp_pkg::PAIR_XY) ? vy_q : vz_q;

  always_comb begin
    wx = vx_q;
    wy = vy_q;
    wz = vz_q;
    if (rotating) begin
      case (pair)
        vrp_pkg::PAIR_YZ: begin
          wy = nu_q;
          wz = nv_q;
        end
        vrp_pkg::PAIR_XY: begin
          wx = nu_q;
          wy = nv_q;
        end
        default: begin
          wx = nu_q;
          wz = nv_q;
        end
      endcase
    end
  end

  // vertex store
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = idx_q;
    mem_dx   = wx;
    mem_dy   = wy;
    mem_dz   = wz;
    if (state_q == vrp_pkg::ST_WBACK) begin
      mem_we = 1'b1;
    end else if (load_go && (32'(vertex_index_i) < VERTEX_COUNT)) begin
      mem_we   = 1'b1;
      mem_addr = IDX_W'(vertex_index_i);
      mem_dx   = load_x_i;
      mem_dy   = load_y_i;
      mem_dz   = load_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[mem_addr] <= mem_dx;
      mem_y[mem_addr] <= mem_dy;
      mem_z[mem_addr] <= mem_dz;
    end
    rd_x_q <= mem_x[idx_q];
    rd_y_q <= mem_y[idx_q];
    rd_z_q <= mem_z[idx_q];
  end

  // multiplier operands
  always_comb begin
    mac_a = {{(vrp_pkg::A_W-CW){u_val[CW-1]}}, u_val};
    mac_b = cos_q;
    case (op_q)
      vrp_pkg::OP_U_COS: mac_b = cos_q;
      vrp_pkg::OP_U_SIN: begin
        mac_a = {{(vrp_pkg::A_W-CW){v_val[CW-1]}}, v_val};
        mac_b = sin_q;
      end
      vrp_pkg::OP_V_COS: mac_a = {{(vrp_pkg::A_W-CW){v_val[CW-1]}}, v_val};
      vrp_pkg::OP_V_SIN: mac_b = sin_q;
      vrp_pkg::OP_X_SCL: begin
        mac_a = {{(vrp_pkg::A_W-CW){vx_q[CW-1]}}, vx_q};
        mac_b = {1'b0, scale_q, 1'b0};
      end
      vrp_pkg::OP_X_CTR: begin
        mac_a = den_q;
        mac_b = {2'b00, ctr_x_q};
      end
      vrp_pkg::OP_Y_SCL: begin
        mac_a = {{(vrp_pkg::A_W-CW){vy_q[CW-1]}}, vy_q};
        mac_b = {1'b0, scale_q, 1'b0};
      end
      vrp_pkg::OP_Y_CTR: begin
        mac_a = den_q;
        mac_b = {2'b00, ctr_y_q};
      end
      default: ;
    endcase
  end

  vrp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_q),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // divider operands: (|n| + |d|/2) / |d|
  assign mag     = acc[vrp_pkg::ACC_W-1] ? -acc : acc;
  assign den_neg = -den_q;
  assign dabs    = den_q[vrp_pkg::DEN_W-1] ? den_neg[vrp_pkg::DABS_W-1:0]
                                           : den_q[vrp_pkg::DABS_W-1:0];
  assign num     = mag + vrp_pkg::ACC_W'(dabs >> 1);

  vrp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (num),
    .den_i   (dabs),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    mac_d    = '0;
    div_go_d = 1'b0;
    case (state_q)
      vrp_pkg::ST_IDLE: begin
        if (rot_go) begin
          state_d = vrp_pkg::ST_READ;
        end
      end
      vrp_pkg::ST_READ: state_d = vrp_pkg::ST_LATCH;
      vrp_pkg::ST_LATCH: begin
        if (kind_q < vrp_pkg::KIND_LIMIT) begin
          op_d        = vrp_pkg::OP_U_COS;
          mac_d.start = 1'b1;
          state_d     = vrp_pkg::ST_MUL;
        end else begin
          state_d = vrp_pkg::ST_WBACK;
        end
      end
      vrp_pkg::ST_MUL: begin
        if (mac_done) begin
          case (op_q)
            vrp_pkg::OP_U_SIN: state_d = vrp_pkg::ST_RND_U;
            vrp_pkg::OP_V_SIN: state_d = vrp_pkg::ST_RND_V;
            vrp_pkg::OP_X_CTR: begin
              if (den_zero) begin
                op_d        = vrp_pkg::OP_Y_SCL;
                mac_d.start = 1'b1;
              end else begin
                div_go_d = 1'b1;
                state_d  = vrp_pkg::ST_DIV;
              end
            end
            vrp_pkg::OP_Y_CTR: begin
              if (den_zero) begin
                state_d = vrp_pkg::ST_EMIT;
              end else begin
                div_go_d = 1'b1;
                state_d  = vrp_pkg::ST_DIV;
              end
            end
            default: begin
              op_d        = op_q + 3'd1;
              mac_d.start = 1'b1;
            end
          endcase
        end
      end
      vrp_pkg::ST_RND_U: begin
        op_d        = vrp_pkg::OP_V_COS;
        mac_d.start = 1'b1;
        state_d     = vrp_pkg::ST_MUL;
      end
      vrp_pkg::ST_RND_V: state_d = vrp_pkg::ST_WBACK;
      vrp_pkg::ST_WBACK: state_d = vrp_pkg::ST_DEN;
      vrp_pkg::ST_DEN: begin
        op_d        = vrp_pkg::OP_X_SCL;
        mac_d.start = 1'b1;
        state_d     = vrp_pkg::ST_MUL;
      end
      vrp_pkg::ST_DIV: begin
        if (div_done) begin
          if (op_q == vrp_pkg::OP_X_CTR) begin
            op_d        = vrp_pkg::OP_Y_SCL;
            mac_d.start = 1'b1;
            state_d     = vrp_pkg::ST_MUL;
          end else begin
            state_d = vrp_pkg::ST_EMIT;
          end
        end
      end
      vrp_pkg::ST_EMIT: state_d = idx_last ? vrp_pkg::ST_IDLE : vrp_pkg::ST_READ;
      default: state_d = vrp_pkg::ST_IDLE;
    endcase
    // even ops open a new sum
    mac_d.clear = !op_d[0];
    case (op_d)
      vrp_pkg::OP_U_SIN: mac_d.neg = odd;
      vrp_pkg::OP_V_SIN: mac_d.neg = !odd;
      vrp_pkg::OP_X_CTR: mac_d.neg = 1'b1;
      default:           mac_d.neg = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vrp_pkg::ST_IDLE;
      op_q     <= vrp_pkg::OP_U_COS;
      mac_q    <= '0;
      div_go_q <= 1'b0;
      idx_q    <= '0;
      kind_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      mac_q    <= mac_d;
      div_go_q <= div_go_d;
      if (rot_go) begin
        idx_q  <= '0;
        kind_q <= rotation_kind_i;
      end else if ((state_q == vrp_pkg::ST_EMIT) && !idx_last) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      vrp_pkg::ST_LATCH: begin
        vx_q <= rd_x_q;
        vy_q <= rd_y_q;
        vz_q <= rd_z_q;
      end
      vrp_pkg::ST_RND_U: nu_q <= vrp_pkg::round_sat(acc);
      vrp_pkg::ST_RND_V: nv_q <= vrp_pkg::round_sat(acc);
      vrp_pkg::ST_WBACK: begin
        vx_q <= wx;
        vy_q <= wy;
        vz_q <= wz;
      end
      vrp_pkg::ST_DEN: begin
        den_q   <= {{(vrp_pkg::DEN_W-CW){vz_q[CW-1]}}, vz_q} + vrp_pkg::DEN_W'(vd_q);
        fault_q <= 1'b0;
      end
      vrp_pkg::ST_MUL: begin
        if (mac_done && den_zero) begin
          if (op_q == vrp_pkg::OP_X_CTR) begin
            px_q    <= {vrp_pkg::PIX_W{1'b1}};
            fault_q <= 1'b1;
          end else if (op_q == vrp_pkg::OP_Y_CTR) begin
            py_q <= {vrp_pkg::PIX_W{1'b1}};
          end
        end
      end
      vrp_pkg::ST_DIV: begin
        if (div_done) begin
          if (op_q == vrp_pkg::OP_X_CTR) begin
            px_q <= quot;
          end else begin
            py_q <= quot;
          end
        end
      end
      default: ;
    endcase
  end

  // result beat
  assign out_valid_o = (state_q == vrp_pkg::ST_EMIT);
  assign out_index_o = 3'(idx_q);
  assign rot_x_o     = vx_q;
  assign rot_y_o     = vy_q;
  assign rot_z_o     = vz_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign div_fault_o = fault_q;
  assign last_o      = idx_last;

endmodule

// File: hw/rtl/vrp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module vrp_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vrp_pkg::mac_req_t               req_i,
  input  logic [vrp_pkg::A_W-1:0]         a_i,
  input  logic [vrp_pkg::CS_W-1:0]        b_i,
  output logic [vrp_pkg::ACC_W-1:0]       acc_o,
  output logic                            done_o
);

  logic [vrp_pkg::ACC_W-1:0] acc_q, acc_d, ash_q;
  logic [vrp_pkg::CS_W-1:0]  bsh_q;
  logic [4:0]                cnt_q;
  logic                      busy_q, neg_q, last, sub;

  assign last   = (cnt_q == 5'(vrp_pkg::CS_W - 1));
  assign done_o = busy_q && last;
  assign acc_o  = acc_q;
  // the top multiplier bit carries negative weight
  assign sub    = neg_q ^ last;

  always_comb begin
    acc_d = acc_q;
    if (bsh_q[0]) begin
      acc_d = sub ? acc_q - ash_q : acc_q + ash_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ash_q <= {{(vrp_pkg::ACC_W-vrp_pkg::A_W){a_i[vrp_pkg::A_W-1]}}, a_i};
      bsh_q <= b_i;
      neg_q <= req_i.neg;
      if (req_i.clear) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q <= acc_d;
      ash_q <= {ash_q[vrp_pkg::ACC_W-2:0], 1'b0};
      bsh_q <= {1'b0, bsh_q[vrp_pkg::CS_W-1:1]};
    end
  end

endmodule

// File: hw/rtl/vrp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_div
// Restoring divider, one quotient bit per cycle, saturating at 16 bits.
// ----------------------------------------------------------------------------
module vrp_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [vrp_pkg::ACC_W-1:0]        num_i,
  input  logic [vrp_pkg::DABS_W-1:0]       den_i,
  output logic [vrp_pkg::PIX_W-1:0]        quot_o,
  output logic                             done_o
);

  localparam int DSH_W = vrp_pkg::DABS_W + vrp_pkg::PIX_W;

  logic [vrp_pkg::ACC_W-1:0] rem_q;
  logic [DSH_W-1:0]          dsh_q;
  logic [vrp_pkg::PIX_W-1:0] q_q;
  logic [4:0]                cnt_q;
  logic                      busy_q, ge, first, fin;

  assign ge     = rem_q >= vrp_pkg::ACC_W'(dsh_q);
  assign first  = (cnt_q == 5'd0);
  assign fin    = (cnt_q == 5'(vrp_pkg::PIX_W));
  assign done_o = busy_q && ((first && ge) || fin);
  assign quot_o = first ? {vrp_pkg::PIX_W{1'b1}} : {q_q[vrp_pkg::PIX_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {vrp_pkg::PIX_W{1'b0}}};
      q_q   <= '0;
    end else if (busy_q) begin
      dsh_q <= {1'b0, dsh_q[DSH_W-1:1]};
      if (!first) begin
        q_q <= {q_q[vrp_pkg::PIX_W-2:0], ge};
        if (ge) begin
          rem_q <= rem_q - vrp_pkg::ACC_W'(dsh_q);
        end
      end
    end
  end

endmodule
